// File: rtl/lkvc_pkg.sv
package lkvc_pkg;

   // fixed field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // default geometry and register reset
   localparam int DEF_ENTRIES = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request opcodes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_COMMIT = 2'd2
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
   } cmd_type;

endpackage

// File: rtl/lkvc_req_if.sv
interface lkvc_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic signed [lkvc_pkg::KEY_W-1:0] key;
   logic signed [lkvc_pkg::VAL_W-1:0] value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

// File: rtl/lkvc_rsp_if.sv
interface lkvc_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic signed [lkvc_pkg::VAL_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink (input valid, input hit, input read_value, output ready);
endinterface

// File: rtl/lkvc_ctrl.sv
module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lkvc_pkg::cmd_type cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            // no request is taken while reset is applied
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = lkvc_pkg::ST_LOOKUP;
            end
         end
         lkvc_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = lkvc_pkg::ST_COMMIT;
         end
         lkvc_pkg::ST_COMMIT: begin
            // commit only once the result register can take the result
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = lkvc_pkg::ST_LOOKUP;
               end else begin
                  state_in = lkvc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
      out_valid_in = cmd.commit || (out_valid_ff && !rsp_ready);
   end

   assign rsp_valid = out_valid_ff;

endmodule

// File: rtl/lkvc_datapath.sv
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cmd_type             cmd,
   input  logic                          req_opcode,
   input  logic [lkvc_pkg::KEY_W-1:0]    req_key,
   input  logic [lkvc_pkg::VAL_W-1:0]    req_value,
   input  logic                          cap_wr,
   input  logic [lkvc_pkg::CAP_W-1:0]    cap_wdata,
   output logic [lkvc_pkg::CAP_W-1:0]    cap_rdata,
   output logic                          rsp_hit,
   output logic [lkvc_pkg::VAL_W-1:0]    rsp_read_value
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   // latched request
   logic                       op_ff;
   logic [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VAL_W-1:0] val_ff;

   // entry state
   logic [lkvc_pkg::KEY_W-1:0] keys_ff [ENTRIES];
   logic [RANK_W-1:0]          rank_ff [ENTRIES];
   logic [RANK_W-1:0]          rank_in [ENTRIES];
   logic [ENTRIES-1:0]         valid_ff, valid_in;
   logic [CNT_W-1:0]           occ_ff, occ_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;
   logic [lkvc_pkg::VAL_W-1:0] value_mem [ENTRIES];

   // lookup results
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] oldest_ff;

   // result register
   logic                       hit_out_ff;
   logic                       use_mem_ff;
   logic [lkvc_pkg::VAL_W-1:0] rdata_ff;

   // commit decode
   logic               is_put, hit_any, do_evict, do_insert;
   logic [ENTRIES-1:0] hit_oh, evict_oh, free_vec, free_oh, kept_valid;
   logic [IDX_W-1:0]   hit_idx, free_idx;
   logic [RANK_W-1:0]  hit_rank;
   logic [CMP_W-1:0]   eff_cap, cap_ext, occ_ext;

   // latch request and run the parallel key compare
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (cmd.lookup) begin
         for (int i = 0; i < ENTRIES; i++) begin
            match_ff[i]  <= valid_ff[i] && (keys_ff[i] == key_ff);
            oldest_ff[i] <= valid_ff[i] && (CNT_W'(rank_ff[i]) == (occ_ff - CNT_W'(1)));
         end
      end
   end

   // hit, eviction and free slot selection
   always_comb begin
      is_put  = (op_ff == lkvc_pkg::OP_PUT);
      hit_any = |match_ff;
      hit_oh  = match_ff & (~match_ff + ENTRIES'(1));

      cap_ext = CMP_W'(cap_ff);
      occ_ext = CMP_W'(occ_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end

      do_evict = is_put && !hit_any && (occ_ext >= eff_cap) && (occ_ff != '0);
      evict_oh = do_evict ? (oldest_ff & (~oldest_ff + ENTRIES'(1))) : '0;
      kept_valid = valid_ff & ~evict_oh;
      free_vec = ~kept_valid;
      free_oh  = free_vec & (~free_vec + ENTRIES'(1));
      do_insert = is_put && !hit_any && (|free_vec);

      hit_idx  = '0;
      free_idx = '0;
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_oh[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (free_oh[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   // next entry state on commit or capacity write
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cap_wr) begin
         valid_in = '0;
         occ_in   = '0;
      end else if (cmd.commit) begin
         if (hit_any) begin
            // touch: younger entries age by one, hit entry becomes newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_oh[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end else if (do_insert) begin
            // insert: every remaining entry ages, new entry is newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (free_oh[i]) begin
                  rank_in[i] = '0;
               end else if (kept_valid[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            valid_in = kept_valid | free_oh;
            occ_in   = occ_ff + CNT_W'(1) - (do_evict ? CNT_W'(1) : CNT_W'(0));
         end
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= lkvc_pkg::CAP_RESET;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         if (cap_wr) begin
            cap_ff <= cap_wdata;
         end
      end
   end

   // ranks and keys
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
         if (cmd.commit && do_insert && free_oh[i]) begin
            keys_ff[i] <= key_ff;
         end
      end
   end

   // value memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (is_put && hit_any) begin
            value_mem[hit_idx] <= val_ff;
         end else if (do_insert) begin
            value_mem[free_idx] <= val_ff;
         end
         rdata_ff   <= value_mem[hit_idx];
         hit_out_ff <= hit_any;
         use_mem_ff <= hit_any && !is_put;
      end
   end

   assign rsp_hit        = hit_out_ff;
   assign rsp_read_value = use_mem_ff ? rdata_ff : '1;
   assign cap_rdata      = cap_ff;

endmodule

// File: rtl/lru_key_value_cache_core.sv
// lru key-value cache, fully associative, least-recently-used replacement
//
// req_ch carries one request: opcode (get or put), key and value; rsp_ch returns
// one result per request: hit and read_value (stored value on a get hit, all
// ones on a get miss and on every put). both use valid/ready, taken when both
// are high at a rising clock edge.
// the csr port holds capacity_in_use at byte address 0; writing it empties the
// cache. write it only while no request is in flight.
// a taken request is latched, the key compare of all entries is registered in
// the lookup step, and the rank and value update plus the registered value
// memory read follow in the commit step, which loads the output register.
// while a request is in flight, the next is taken in its commit step, as the
// compare and update steps share the entry state.
// the result sits in an output register; a stalled receiver holds it there and
// the next request is still taken, its update waiting until the register frees.
// reset empties the cache, sets capacity to 16 and drops any pending result.
module lru_key_value_cache_core #(
   parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   lkvc_req_if.sink                           req_ch,
   lkvc_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   lkvc_pkg::cmd_type           cmd;
   logic                        cap_wr;
   logic [lkvc_pkg::CAP_W-1:0]  cap_rdata;
   logic [lkvc_pkg::VAL_W-1:0]  read_value;

   // csr access, single register at address zero
   assign csr_pready = 1'b1;
   assign cap_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == '0);
   assign csr_prdata = lkvc_pkg::CSR_DATA_W'(cap_rdata);

   // controller
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // datapath
   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_ch.opcode),
      .req_key        (req_ch.key),
      .req_value      (req_ch.value),
      .cap_wr         (cap_wr),
      .cap_wdata      (csr_pwdata[lkvc_pkg::CAP_W-1:0]),
      .cap_rdata      (cap_rdata),
      .rsp_hit        (rsp_ch.hit),
      .rsp_read_value (read_value)
   );

   assign rsp_ch.read_value = read_value;

   // a taken request always spends the next cycle in lookup
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while lookup pending");

   // a commit never overwrites a result that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwritten");

   // lookup is followed by a commit unless the result register is blocked
   a_lookup_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> (cmd.commit || (rsp_ch.valid && !rsp_ch.ready)))
      else $error("lookup not followed by commit");

   // lookup and commit never overlap
   a_steps_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.lookup, cmd.commit}))
      else $error("lookup and commit together");

endmodule

// File: dv/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache_core;

   localparam int SLOTS = lkvc_pkg::DEF_ENTRIES;
   localparam int POOL_MAX = 24;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT = 400_000;
   localparam logic [lkvc_pkg::CSR_ADDR_W-1:0] CAP_ADDR = '0;

   typedef struct packed {
      logic                       hit;
      logic [lkvc_pkg::VAL_W-1:0] read_value;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [lkvc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lkvc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lkvc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   lkvc_req_if req_if();
   lkvc_rsp_if rsp_if();

   lru_key_value_cache_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // cache image kept alongside the block
   logic [lkvc_pkg::KEY_W-1:0] slot_key [SLOTS];
   logic [lkvc_pkg::VAL_W-1:0] slot_value [SLOTS];
   bit                         slot_live [SLOTS];
   int unsigned                slot_age [SLOTS];
   int unsigned                live_count;
   logic [lkvc_pkg::CAP_W-1:0] capacity_reg = lkvc_pkg::CAP_RESET;

   cache_result_type pending_lookups[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  no_stall = 1'b0;
   int  stall_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_cache();
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_age[i] = 0;
      end
      live_count = 0;
   endfunction

   function automatic void note_mismatch(string msg);
      if (mismatch_count < 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endfunction

   // apply one request to the cache image, return what the block should answer
   function automatic cache_result_type lru_access(lkvc_pkg::opcode_type op,
                                                   logic [lkvc_pkg::KEY_W-1:0] key,
                                                   logic [lkvc_pkg::VAL_W-1:0] data);
      cache_result_type res;
      int hit_slot;
      int free_slot;
      int unsigned limit;
      int unsigned age;
      bit evicted;
      hit_slot = -1;
      free_slot = -1;
      evicted = 1'b0;
      res.hit = 1'b0;
      res.read_value = '1;
      for (int i = 0; i < SLOTS; i++)
         if (hit_slot < 0 && slot_live[i] && slot_key[i] == key) hit_slot = i;
      if (hit_slot >= 0) begin
         // refresh: younger entries age by one, this one becomes newest
         res.hit = 1'b1;
         age = slot_age[hit_slot];
         for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
         slot_age[hit_slot] = 0;
         if (op == lkvc_pkg::OP_GET) res.read_value = slot_value[hit_slot];
         else slot_value[hit_slot] = data;
      end else if (op == lkvc_pkg::OP_PUT) begin
         // zero capacity acts as one, oversize saturates to the slot count
         limit = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
         if (live_count >= limit && live_count > 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (!evicted && slot_live[i] && slot_age[i] == live_count - 1) begin
                  slot_live[i] = 1'b0;
                  slot_age[i] = 0;
                  evicted = 1'b1;
               end
            if (evicted) live_count--;
         end
         for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && !slot_live[i]) free_slot = i;
         if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_live[i]) slot_age[i]++;
            slot_live[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_value[free_slot] = data;
            slot_age[free_slot] = 0;
            live_count++;
         end
      end
      return res;
   endfunction

   // request capture and result check
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            pending_lookups.push_back(lru_access(lkvc_pkg::opcode_type'(req_if.opcode),
                                                 req_if.key, req_if.value));
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_lookups.size() == 0) begin
               note_mismatch($sformatf("unexpected result hit=%0b read_value=%h",
                                       rsp_if.hit, rsp_if.read_value));
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_if.hit !== want.hit)
                  note_mismatch($sformatf("hit expected %0b actual %0b",
                                          want.hit, rsp_if.hit));
               if (rsp_if.read_value !== want.read_value)
                  note_mismatch($sformatf("read_value expected %h actual %h",
                                          want.read_value, rsp_if.read_value));
            end
         end
      end
   end

   // result backpressure, occasional multi-cycle stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready = 1'b0;
      end else if (!no_stall && $urandom_range(99) < 3) begin
         stall_left = $urandom_range(1, 3);
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_lru_key_value_cache_core: FAIL");
         $finish;
      end
   end

   // stop sending and wait for every outstanding result
   task automatic settle_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(lkvc_pkg::opcode_type op, logic [lkvc_pkg::KEY_W-1:0] key,
                               logic [lkvc_pkg::VAL_W-1:0] data);
      if (!no_stall && $urandom_range(99) < 8) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.opcode = op;
      req_if.key = key;
      req_if.value = data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic check_capacity(logic [lkvc_pkg::CAP_W-1:0] want);
      logic [lkvc_pkg::CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      csr_paddr = CAP_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== {{(lkvc_pkg::CSR_DATA_W-lkvc_pkg::CAP_W){1'b0}}, want})
         note_mismatch($sformatf("capacity readback expected %0d actual %h", want, got));
   endtask

   // every write empties the cache, even with an unchanged value
   task automatic write_capacity(logic [lkvc_pkg::CSR_DATA_W-1:0] word);
      settle_idle();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = CAP_ADDR;
      csr_pwdata = word;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      capacity_reg = word[lkvc_pkg::CAP_W-1:0];
      clear_cache();
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      check_capacity(word[lkvc_pkg::CAP_W-1:0]);
   endtask

   task automatic test_after_reset();
      check_capacity(lkvc_pkg::CAP_RESET);
      send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1111_1111);
   endtask

   task automatic test_field_extremes();
      send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_request(lkvc_pkg::OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_request(lkvc_pkg::OP_PUT, 32'hffff_ffff, 32'h0000_0000);
      send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(lkvc_pkg::OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
      send_request(lkvc_pkg::OP_GET, 32'hffff_ffff, 32'h5555_5555);
      send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'haaaa_aaaa);
   endtask

   // put on a present key overwrites without eviction
   task automatic test_put_update();
      send_request(lkvc_pkg::OP_PUT, 32'h7fff_ffff, 32'h1234_5678);
      send_request(lkvc_pkg::OP_GET, 32'h7fff_ffff, 32'h0000_0000);
   endtask

   // replacement order at capacity two, refresh by get and by put
   task automatic test_lru_order();
      write_capacity(32'd2);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_00a1, 32'h0000_0001);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_00b2, 32'h0000_0002);
      send_request(lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_00c3, 32'h0000_0003);
      send_request(lkvc_pkg::OP_GET, 32'h0000_00b2, 32'h0000_0000);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_00a1, 32'h0000_0011);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_00d4, 32'h0000_0004);
      send_request(lkvc_pkg::OP_GET, 32'h0000_00c3, 32'h0000_0000);
      send_request(lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000);
      write_capacity(32'd2);
      send_request(lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000);
   endtask

   // zero capacity holds a single entry
   task automatic test_capacity_edges();
      write_capacity(32'd0);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_0e01, 32'hdead_0001);
      send_request(lkvc_pkg::OP_PUT, 32'h0000_0e02, 32'hdead_0002);
      send_request(lkvc_pkg::OP_GET, 32'h0000_0e01, 32'h0000_0000);
      send_request(lkvc_pkg::OP_GET, 32'h0000_0e02, 32'h0000_0000);
   endtask

   // random gets and puts over a key pool a little larger than the capacity
   task automatic test_random_traffic(logic [lkvc_pkg::CSR_DATA_W-1:0] word, int count,
                                      bit hold_midway);
      logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
      logic [lkvc_pkg::KEY_W-1:0] key;
      int unsigned limit;
      int pool_size;
      write_capacity(word);
      limit = (word[lkvc_pkg::CAP_W-1:0] == 0) ? 1 :
              (word[lkvc_pkg::CAP_W-1:0] > SLOTS) ? SLOTS : word[lkvc_pkg::CAP_W-1:0];
      pool_size = limit + $urandom_range(1, POOL_MAX - SLOTS);
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      key_pool[0] = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      for (int n = 0; n < count; n++) begin
         if (hold_midway && n == count / 2) settle_idle();
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
                                         : 32'($urandom);
         send_request(lkvc_pkg::opcode_type'($urandom_range(1)), key, 32'($urandom));
      end
   endtask

   // both sides always ready for a long stretch
   task automatic test_back_to_back();
      no_stall = 1'b1;
      test_random_traffic(32'd8, 200, 1'b0);
      no_stall = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = lkvc_pkg::OP_GET;
      req_if.key = '0;
      req_if.value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      clear_cache();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_field_extremes();
      test_put_update();
      test_lru_order();
      test_capacity_edges();
      test_random_traffic(32'd16, 150, 1'b1);
      test_random_traffic(32'd1, 100, 1'b0);
      test_random_traffic(32'd5, 120, 1'b0);
      test_random_traffic({27'($urandom), 5'd0}, 100, 1'b0);
      test_random_traffic(32'd31, 150, 1'b1);
      test_random_traffic(32'hffff_ffe0 | 32'd17, 100, 1'b0);
      test_random_traffic(32'd3, 100, 1'b0);
      test_random_traffic(32'($urandom_range(1, 16)), 120, 1'b0);
      test_back_to_back();

      settle_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0)
         $display("tb_lru_key_value_cache_core: PASS");
      else
         $display("tb_lru_key_value_cache_core: FAIL");
      $finish;
   end

endmodule
